/* sv/sba_pkg.sv */
// Shared types and constants for the superblock bump allocator.
// No dependencies; used by every module of the block.
package sba_pkg;

    localparam int unsigned REQ_W  = 20;
    localparam int unsigned HEAP_W = 4;
    localparam int unsigned ADDR_W = 26;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned HDR_BYTES = 16;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_bytes;
        logic [HEAP_W-1:0] heap_index;
        logic [ADDR_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [STAT_W-1:0] status;
        logic              block_recycled;
    } t_rsp;

endpackage

/* sv/sba_front.sv */
// Front end: takes requests, classifies them and holds them in a short queue.
// Depends on sba_pkg.
module sba_front #(
    parameter int unsigned BLOCK_BYTES = 1048576,
    parameter int unsigned HEAP_COUNT  = 16,
    parameter int unsigned HEAP_IW     = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sba_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic          o_alloc,
    output logic          o_too_big,
    output logic [sba_pkg::REQ_W:0]  o_bytes,
    output logic [HEAP_IW-1:0]       o_heap,
    output logic [sba_pkg::ADDR_W-1:0] o_addr
);
    import sba_pkg::*;

    typedef struct packed {
        logic              alloc;
        logic              too_big;
        logic [REQ_W:0]    bytes;
        logic [HEAP_IW-1:0] heap;
        logic [ADDR_W-1:0] addr;
    } t_cls;

    // two-entry queue
    t_cls       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_cls       n_ent;
    logic [REQ_W:0] n_bytes;
    logic           push;

    always_comb begin
        n_bytes       = {1'b0, i_req.request_bytes} + (REQ_W+1)'(HDR_BYTES);
        n_ent.alloc   = (i_req.action == ACT_ALLOC);
        n_ent.bytes   = n_bytes;
        n_ent.too_big = (32'(n_bytes) >= BLOCK_BYTES);
        // heap index folded into range through a constant lookup
        n_ent.heap    = '0;
        for (int k = 0; k < (1 << HEAP_W); k++) begin
            if (i_req.heap_index == HEAP_W'(k)) n_ent.heap = HEAP_IW'(k % HEAP_COUNT);
        end
        n_ent.addr    = i_req.release_address;
    end

    assign push    = i_start && !o_full;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_alloc   = r_q[r_rd].alloc;
    assign o_too_big = r_q[r_rd].too_big;
    assign o_bytes   = r_q[r_rd].bytes;
    assign o_heap    = r_q[r_rd].heap;
    assign o_addr    = r_q[r_rd].addr;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_ent;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

/* sv/sba_back.sv */
// Back end: block tables, free FIFO and the read-modify-write per request (table read, then update).
// Depends on sba_pkg.
module sba_back #(
    parameter int unsigned BLOCK_BYTES = 1048576,
    parameter int unsigned BLOCK_COUNT = 64,
    parameter int unsigned HEAP_COUNT  = 16,
    parameter int unsigned HEAP_IW     = 4,
    parameter int unsigned BLK_W       = 6,
    parameter int unsigned OFF_W       = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_alloc,
    input  logic          i_too_big,
    input  logic [sba_pkg::REQ_W:0]  i_bytes,
    input  logic [HEAP_IW-1:0]       i_heap,
    input  logic [sba_pkg::ADDR_W-1:0] i_addr,
    output logic          o_pop,
    output logic          o_done,
    output sba_pkg::t_rsp o_rsp
);
    import sba_pkg::*;

    localparam int unsigned LIVE_W = 17;
    localparam int unsigned CNT_W  = BLK_W + 1;
    localparam int unsigned BSH    = $clog2(BLOCK_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_INIT} t_state;

    // per-heap current block in flops; per-block tables cleared by the init pass
    logic [BLK_W-1:0]  r_cur  [HEAP_COUNT];
    logic              r_held [HEAP_COUNT];
    logic [OFF_W-1:0]  r_fill [BLOCK_COUNT];
    logic [LIVE_W-1:0] r_live [BLOCK_COUNT];
    logic              r_act  [BLOCK_COUNT];
    // free FIFO memory
    logic [BLK_W-1:0]  r_fq   [BLOCK_COUNT];
    logic [BLK_W-1:0]  r_head, r_tail, r_fqhd;
    logic [CNT_W-1:0]  r_cnt;
    logic [BLK_W-1:0]  r_init;

    t_state            r_state;
    logic [OFF_W-1:0]  r_cfill;
    logic [LIVE_W-1:0] r_clive;
    logic              r_cact;
    logic [BLK_W-1:0]  r_cblk;

    logic [ADDR_W-1:0] fblk_full;
    logic [BLK_W-1:0]  fblk;
    logic [BLK_W-1:0]  rd_blk;
    logic              f_oob;

    always_comb begin
        fblk_full = i_addr >> BSH;
        fblk      = BLK_W'(fblk_full);
        f_oob     = (32'(fblk_full) >= BLOCK_COUNT);
        rd_blk    = i_alloc ? r_cur[i_heap] : fblk;
    end

    function automatic logic [BLK_W-1:0] wrap_inc(input logic [BLK_W-1:0] v);
        wrap_inc = (32'(v) + 1 >= BLOCK_COUNT) ? '0 : v + 1'b1;
    endfunction

    logic              a_held, a_fits, a_zero, push, pop;
    logic [BLK_W-1:0]  a_blk, push_blk;
    logic [OFF_W:0]    a_sum;
    logic [ADDR_W-1:0] a_addr;
    t_rsp              n_rsp;

    // execute decision on registered table reads
    always_comb begin
        a_held  = r_held[i_heap];
        a_sum   = {1'b0, r_cfill} + (OFF_W+1)'(i_bytes);
        a_fits  = a_held && (32'(a_sum) < BLOCK_BYTES);
        a_zero  = (r_clive == '0);
        push    = 1'b0;
        pop     = 1'b0;
        push_blk = r_cblk;
        a_blk   = r_cblk;
        n_rsp   = '0;
        if (i_alloc) begin
            if (i_too_big) begin
                n_rsp.status = ST_TOO_BIG;
            end else if (!a_fits && r_cnt == '0) begin
                n_rsp.status = ST_NO_BLOCK;
            end else begin
                if (!a_fits) begin
                    pop   = 1'b1;
                    a_blk = r_fqhd;
                    push  = a_held && a_zero;
                end
                n_rsp.status = ST_OK;
            end
        end else begin
            if (f_oob || a_zero) begin
                n_rsp.status = ST_BAD_FREE;
            end else begin
                push = (r_clive == LIVE_W'(1)) && !r_cact;
            end
        end
        if (push && 32'(r_cnt) + (pop ? 0 : 1) > BLOCK_COUNT) push = 1'b0;
        n_rsp.block_recycled = push;
        a_addr = ADDR_W'(a_blk) << BSH;
        if (n_rsp.status == ST_OK && i_alloc)
            n_rsp.granted_address = a_addr + ADDR_W'(pop ? '0 : r_cfill)
                                    + ADDR_W'(HDR_BYTES);
    end

    assign o_pop = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        // read stage
        if (r_state == S_IDLE && i_valid) begin
            r_cblk  <= rd_blk;
            r_cfill <= r_fill[rd_blk];
            r_clive <= r_live[rd_blk];
            r_cact  <= r_act[rd_blk];
        end
        r_fqhd <= r_fq[r_head];
        if (r_state == S_INIT) r_fq[r_init] <= r_init;
        else if (r_state == S_EXEC && push) r_fq[r_tail] <= push_blk;
        o_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= CNT_W'(BLOCK_COUNT);
            o_done  <= 1'b0;
            for (int h = 0; h < HEAP_COUNT; h++) r_held[h] <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    // one table entry cleared per cycle
                    r_fill[r_init] <= '0;
                    r_live[r_init] <= '0;
                    r_act[r_init]  <= 1'b0;
                    r_init <= wrap_inc(r_init);
                    if (32'(r_init) == BLOCK_COUNT - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (pop) begin
                        r_head <= wrap_inc(r_head);
                        r_act[r_fqhd]  <= 1'b1;
                        r_cur[i_heap]  <= r_fqhd;
                        r_held[i_heap] <= 1'b1;
                        if (a_held) r_act[r_cblk] <= 1'b0;
                    end
                    if (push) r_tail <= wrap_inc(r_tail);
                    r_cnt <= r_cnt - CNT_W'(pop) + CNT_W'(push);
                    if (i_alloc && n_rsp.status == ST_OK) begin
                        if (push) r_fill[r_cblk] <= '0;
                        r_fill[a_blk] <= OFF_W'((pop ? '0 : r_cfill) + OFF_W'(i_bytes));
                        r_live[a_blk] <= pop ? LIVE_W'(1) : r_clive + 1'b1;
                    end else if (!i_alloc && n_rsp.status == ST_OK) begin
                        r_live[r_cblk] <= r_clive - 1'b1;
                        if (push) r_fill[r_cblk] <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/superblock_bump_allocator.sv */
// Superblock bump allocator. Each request passes through the back end as a table read, then
// an update; the back end takes one request at a time, and o_strobe is registered from the
// update step. A two-entry queue decouples intake; busy rises only when it is full.
// After reset the free list and block tables are set up, one entry at a time, before any
// request executes; requests may be queued meanwhile. Results cannot be stalled.
module superblock_bump_allocator #(
    parameter int unsigned BLOCK_BYTES = 1048576,
    parameter int unsigned BLOCK_COUNT = 64,
    parameter int unsigned HEAP_COUNT  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sba_pkg::t_req i_req,
    output logic          o_strobe,
    output sba_pkg::t_rsp o_rsp
);
    import sba_pkg::*;

    localparam int unsigned HEAP_IW = (HEAP_COUNT > 1) ? $clog2(HEAP_COUNT) : 1;
    localparam int unsigned BLK_W   = $clog2(BLOCK_COUNT);
    localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES) + 1;

    logic              q_valid, q_alloc, q_big, q_pop;
    logic [REQ_W:0]    q_bytes;
    logic [HEAP_IW-1:0] q_heap;
    logic [ADDR_W-1:0] q_addr;

    sba_front #(.BLOCK_BYTES(BLOCK_BYTES), .HEAP_COUNT(HEAP_COUNT), .HEAP_IW(HEAP_IW)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_req, .i_pop(q_pop), .o_full(busy),
        .o_valid(q_valid), .o_alloc(q_alloc), .o_too_big(q_big), .o_bytes(q_bytes),
        .o_heap(q_heap), .o_addr(q_addr)
    );

    sba_back #(.BLOCK_BYTES(BLOCK_BYTES), .BLOCK_COUNT(BLOCK_COUNT), .HEAP_COUNT(HEAP_COUNT),
               .HEAP_IW(HEAP_IW), .BLK_W(BLK_W), .OFF_W(OFF_W)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_alloc(q_alloc), .i_too_big(q_big),
        .i_bytes(q_bytes), .i_heap(q_heap), .i_addr(q_addr), .o_pop(q_pop),
        .o_done(o_strobe), .o_rsp
    );
endmodule
